FILE: sv/rau_pkg.sv
// Shared types, codes and field layout for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int unsigned NUM_W = 64;
  localparam int unsigned DEN_W = 63;
  localparam int unsigned FUNC_W = 4;

  localparam int unsigned IN_TDATA_W = 256;
  localparam int unsigned IN_TUSER_W = 4;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 5;

  localparam int unsigned A_NUM_LSB = 0;
  localparam int unsigned A_DEN_LSB = 64;
  localparam int unsigned B_NUM_LSB = 127;
  localparam int unsigned B_DEN_LSB = 191;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_MUL   = 4'd2,
    FN_DIV   = 4'd3,
    FN_NEG   = 4'd4,
    FN_RECIP = 4'd5,
    FN_ABS   = 4'd6,
    FN_CMP   = 4'd7,
    FN_MOD   = 4'd8,
    FN_MAX   = 4'd9,
    FN_MIN   = 4'd10
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_NOT_INT  = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RED_START,
    BK_RED_GCD,
    BK_RED_DIV,
    BK_MUL_START,
    BK_MUL,
    BK_COMBINE,
    BK_MOD,
    BK_FIN
  } back_state_e;

  // Operands are held zero-padded to 64 bits; the back end uses the low bits.
  typedef struct packed {
    func_e       func;
    status_e     status;
    logic [63:0] a_num;
    logic [63:0] a_den;
    logic [63:0] b_num;
    logic [63:0] b_den;
  } entry_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    status_e          status;
    logic             less;
    logic             equal;
    logic             greater;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/rational_arithmetic_unit.sv
// Work per word: mod runs one division and no gcd; the unary paths run one gcd reduction (a gcd
// and a division); add and mul run two gcd reductions and three shift-add products; the other
// operations run three shift-add products and, all but compare, one gcd reduction.
// One word is worked at a time by the back-end sequencer; a two-entry queue and the result
// register let words be taken in while a result waits. rst_ni clears all control state
// asynchronously; the queue comes out of reset empty and no result is pending.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_num[63:0], a_den[126:64], b_num[190:127], b_den[253:191], zero pad
  input  wire logic [rau_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func[3:0]
  input  wire logic [rau_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // res_num[63:0], res_den[126:64], zero pad
  output logic [rau_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // status[1:0], less[2], equal[3], greater[4]
  output logic [rau_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  rau_pkg::entry_t push_entry, pop_entry;
  rau_pkg::result_t res;

  rau_front #(.W(VALUE_WIDTH)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  rau_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  rau_back #(.W(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.den, res.num};
  assign m_axis_tuser = {res.greater, res.equal, res.less, res.status};

endmodule
`default_nettype wire

FILE: sv/rau_front.sv
// Front end: accepts words, masks operands and resolves operand errors.
`default_nettype none
module rau_front #(
  parameter int unsigned W = 64
) (
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [rau_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic [rau_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  output logic                                     push_valid_o,
  input  wire logic                                push_ready_i,
  output rau_pkg::entry_t                          push_entry_o
);

  logic [rau_pkg::FUNC_W-1:0] raw;
  logic [W-1:0] a_num_w, b_num_w;
  logic [W-2:0] a_den_w, b_den_w;
  logic unary;
  rau_pkg::func_e   func;
  rau_pkg::status_e status;

  assign s_axis_tready = push_ready_i;
  assign push_valid_o  = s_axis_tvalid;

  always_comb begin
    raw     = s_axis_tuser[rau_pkg::FUNC_W-1:0];
    a_num_w = s_axis_tdata[rau_pkg::A_NUM_LSB +: W];
    a_den_w = s_axis_tdata[rau_pkg::A_DEN_LSB +: (W-1)];
    b_num_w = s_axis_tdata[rau_pkg::B_NUM_LSB +: W];
    b_den_w = s_axis_tdata[rau_pkg::B_DEN_LSB +: (W-1)];
    unary   = raw inside {rau_pkg::FN_NEG, rau_pkg::FN_RECIP, rau_pkg::FN_ABS};
    func    = rau_pkg::FN_ADD;
    status  = rau_pkg::ST_OK;
    if (raw > rau_pkg::FN_MIN) begin
      status = rau_pkg::ST_RANGE;
    end else begin
      func = rau_pkg::func_e'(raw);
      if (a_den_w == '0 || (!unary && b_den_w == '0)) begin
        status = rau_pkg::ST_DIV_ZERO;
      end else begin
        case (func)
          rau_pkg::FN_DIV: begin
            if (b_num_w == '0) status = rau_pkg::ST_DIV_ZERO;
          end
          rau_pkg::FN_RECIP: begin
            if (a_num_w == '0) status = rau_pkg::ST_DIV_ZERO;
          end
          rau_pkg::FN_MOD: begin
            if (a_den_w != (W-1)'(1) || b_den_w != (W-1)'(1)) begin
              status = rau_pkg::ST_NOT_INT;
            end else if (b_num_w == '0) begin
              status = rau_pkg::ST_DIV_ZERO;
            end
          end
          default: ;
        endcase
      end
    end
    push_entry_o.func   = func;
    push_entry_o.status = status;
    push_entry_o.a_num  = 64'(a_num_w);
    push_entry_o.a_den  = 64'(a_den_w);
    push_entry_o.b_num  = 64'(b_num_w);
    push_entry_o.b_den  = 64'(b_den_w);
  end

endmodule
`default_nettype wire

FILE: sv/rau_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module rau_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire rau_pkg::entry_t push_entry_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output rau_pkg::entry_t      pop_entry_o
);

  rau_pkg::entry_t mem_q [rau_pkg::QUEUE_DEPTH];
  logic [rau_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [rau_pkg::QCNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != rau_pkg::QCNT_W'(rau_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule
`default_nettype wire

FILE: sv/rau_gcd.sv
// Binary gcd unit, one shift or subtract per cycle.
`default_nettype none
module rau_gcd #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              done_o,
  output logic [W-1:0]      g_o
);

  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]  u_q, v_q, u_d, v_d, g_q, g_d;
  logic [KW-1:0] k_q, k_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W-1:0]  rest;

  assign done_o = done_q;
  assign g_o    = g_q;

  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    k_d    = k_q;
    g_d    = g_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rest   = u_q | v_q;
    if (start_i) begin
      u_d    = a_i;
      v_d    = b_i;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (u_q == '0 || v_q == '0) begin
        // gcd(0, 0) is taken as 1.
        g_d    = (rest == '0) ? W'(1) : W'(rest << k_q);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!u_q[0] && !v_q[0]) begin
        u_d = u_q >> 1;
        v_d = v_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_q >= v_q) begin
        u_d = u_q - v_q;
      end else begin
        v_d = v_q - u_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    k_q <= k_d;
    g_q <= g_d;
  end

endmodule
`default_nettype wire

FILE: sv/rau_div.sv
// Restoring divider with two dividend lanes sharing one divisor, one bit per cycle.
`default_nettype none
module rau_div #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] divisor_i,
  input  wire logic [W-1:0] dividend0_i,
  input  wire logic [W-1:0] dividend1_i,
  output logic              done_o,
  output logic [W-1:0]      quo0_o,
  output logic [W-1:0]      quo1_o,
  output logic [W-1:0]      rem0_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  dsr_q, dsr_d, q0_q, q0_d, q1_q, q1_d, r0_q, r0_d, r1_q, r1_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    t0, t1;

  assign done_o = done_q;
  assign quo0_o = q0_q;
  assign quo1_o = q1_q;
  assign rem0_o = r0_q;

  always_comb begin
    dsr_d  = dsr_q;
    q0_d   = q0_q;
    q1_d   = q1_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    t0     = {r0_q, q0_q[W-1]};
    t1     = {r1_q, q1_q[W-1]};
    if (start_i) begin
      dsr_d  = divisor_i;
      q0_d   = dividend0_i;
      q1_d   = dividend1_i;
      r0_d   = '0;
      r1_d   = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (t0 >= {1'b0, dsr_q}) begin
        r0_d = W'(t0 - {1'b0, dsr_q});
        q0_d = {q0_q[W-2:0], 1'b1};
      end else begin
        r0_d = W'(t0);
        q0_d = {q0_q[W-2:0], 1'b0};
      end
      if (t1 >= {1'b0, dsr_q}) begin
        r1_d = W'(t1 - {1'b0, dsr_q});
        q1_d = {q1_q[W-2:0], 1'b1};
      end else begin
        r1_d = W'(t1);
        q1_d = {q1_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    q0_q  <= q0_d;
    q1_q  <= q1_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    cnt_q <= cnt_d;
  end

endmodule
`default_nettype wire

FILE: sv/rau_back.sv
// Back end: sequencer with a shift-add multiplier, gcd reduction and result register.
`default_nettype none
module rau_back #(
  parameter int unsigned W = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  input  wire rau_pkg::entry_t pop_entry_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output rau_pkg::result_t     res_o
);

  localparam int unsigned MCW = $clog2(W);

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? W'(-x) : x;
  endfunction

  function automatic logic [W-1:0] enc(input logic neg, input logic [W-1:0] q);
    enc = neg ? W'(-q) : q;
  endfunction

  rau_pkg::back_state_e state_q, state_d;
  rau_pkg::func_e       func_q, func_d;
  rau_pkg::status_e     st_q, st_d;
  rau_pkg::result_t     out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 red_pre_q, red_pre_d;
  logic                 lt_q, lt_d, eq_q, eq_d, gt_q, gt_d;
  logic [W-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [W-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [W-1:0] p0_q, p0_d, p1_q, p1_d, p2_q, p2_d;
  logic [W-1:0] mcand_q, mcand_d, mplier_q, mplier_d, acc_q, acc_d;
  logic [MCW-1:0] mcnt_q, mcnt_d;
  logic [1:0]   midx_q, midx_d;

  logic         gcd_start, gcd_done;
  logic [W-1:0] gcd_g;
  logic         div_start, div_done;
  logic [W-1:0] div_dsr, div_dd0, div_dd1, div_q0, div_q1, div_r0;
  logic [W-1:0] ent_an, ent_bn, modr, mn, md;
  logic         pick_b, out_free;

  rau_gcd #(.W(W)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (mag(rn_q)),
    .b_i     (mag(rd_q)),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div #(.W(W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .divisor_i   (div_dsr),
    .dividend0_i (div_dd0),
    .dividend1_i (div_dd1),
    .done_o      (div_done),
    .quo0_o      (div_q0),
    .quo1_o      (div_q1),
    .rem0_o      (div_r0)
  );

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign out_free    = !out_valid_q || res_ready_i;
  assign ent_an      = pop_entry_i.a_num[W-1:0];
  assign ent_bn      = pop_entry_i.b_num[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    st_q     <= st_d;
    out_q    <= out_d;
    red_pre_q <= red_pre_d;
    lt_q     <= lt_d;
    eq_q     <= eq_d;
    gt_q     <= gt_d;
    an_q     <= an_d;
    ad_q     <= ad_d;
    bn_q     <= bn_d;
    bd_q     <= bd_d;
    rn_q     <= rn_d;
    rd_q     <= rd_d;
    p0_q     <= p0_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    mcnt_q   <= mcnt_d;
    midx_q   <= midx_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    red_pre_d   = red_pre_q;
    lt_d        = lt_q;
    eq_d        = eq_q;
    gt_d        = gt_q;
    an_d        = an_q;
    ad_d        = ad_q;
    bn_d        = bn_q;
    bd_d        = bd_q;
    rn_d        = rn_q;
    rd_d        = rd_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    midx_d      = midx_q;
    pop_ready_o = 1'b0;
    gcd_start   = 1'b0;
    div_start   = 1'b0;
    div_dsr     = gcd_g;
    div_dd0     = mag(rn_q);
    div_dd1     = mag(rd_q);
    pick_b      = 1'b0;
    modr        = '0;
    mn          = mag(rn_q);
    md          = mag(rd_q);

    if (out_valid_q && res_ready_i) out_valid_d = 1'b0;

    case (state_q)
      rau_pkg::BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          func_d    = pop_entry_i.func;
          st_d      = pop_entry_i.status;
          an_d      = ent_an;
          ad_d      = pop_entry_i.a_den[W-1:0];
          bn_d      = ent_bn;
          bd_d      = pop_entry_i.b_den[W-1:0];
          red_pre_d = 1'b0;
          midx_d    = '0;
          lt_d      = 1'b0;
          eq_d      = 1'b0;
          gt_d      = 1'b0;
          if (pop_entry_i.status != rau_pkg::ST_OK) begin
            state_d = rau_pkg::BK_FIN;
          end else begin
            case (pop_entry_i.func)
              rau_pkg::FN_ADD, rau_pkg::FN_MUL: begin
                // The first operand is brought to lowest terms before the products.
                rn_d      = ent_an;
                rd_d      = pop_entry_i.a_den[W-1:0];
                red_pre_d = 1'b1;
                state_d   = rau_pkg::BK_RED_START;
              end
              rau_pkg::FN_NEG: begin
                rn_d    = W'(-ent_an);
                rd_d    = pop_entry_i.a_den[W-1:0];
                state_d = rau_pkg::BK_RED_START;
              end
              rau_pkg::FN_RECIP: begin
                rn_d    = pop_entry_i.a_den[W-1:0];
                rd_d    = ent_an;
                state_d = rau_pkg::BK_RED_START;
              end
              rau_pkg::FN_ABS: begin
                rn_d    = mag(ent_an);
                rd_d    = pop_entry_i.a_den[W-1:0];
                state_d = rau_pkg::BK_RED_START;
              end
              rau_pkg::FN_MOD: begin
                div_start = 1'b1;
                div_dsr   = mag(ent_bn);
                div_dd0   = mag(ent_an);
                div_dd1   = '0;
                state_d   = rau_pkg::BK_MOD;
              end
              default: state_d = rau_pkg::BK_MUL_START;
            endcase
          end
        end
      end

      rau_pkg::BK_RED_START: begin
        gcd_start = 1'b1;
        state_d   = rau_pkg::BK_RED_GCD;
      end

      rau_pkg::BK_RED_GCD: begin
        if (gcd_done) begin
          div_start = 1'b1;
          state_d   = rau_pkg::BK_RED_DIV;
        end
      end

      rau_pkg::BK_RED_DIV: begin
        if (div_done) begin
          if (red_pre_q) begin
            an_d      = enc(rn_q[W-1], div_q0);
            ad_d      = enc(rd_q[W-1], div_q1);
            red_pre_d = 1'b0;
            state_d   = rau_pkg::BK_MUL_START;
          end else begin
            rn_d    = enc(rn_q[W-1], div_q0);
            rd_d    = enc(rd_q[W-1], div_q1);
            state_d = rau_pkg::BK_FIN;
          end
        end
      end

      rau_pkg::BK_MUL_START: begin
        acc_d  = '0;
        mcnt_d = '0;
        case (midx_q)
          2'd0: begin
            mcand_d  = an_q;
            mplier_d = (func_q == rau_pkg::FN_MUL) ? bn_q : bd_q;
          end
          2'd1: begin
            mcand_d  = bn_q;
            mplier_d = ad_q;
          end
          default: begin
            mcand_d  = ad_q;
            mplier_d = bd_q;
          end
        endcase
        state_d = rau_pkg::BK_MUL;
      end

      rau_pkg::BK_MUL: begin
        acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        mcnt_d   = mcnt_q + 1'b1;
        if (mcnt_q == MCW'(W-1)) begin
          case (midx_q)
            2'd0:    p0_d = acc_d;
            2'd1:    p1_d = acc_d;
            default: p2_d = acc_d;
          endcase
          if (midx_q == 2'd2) begin
            state_d = rau_pkg::BK_COMBINE;
          end else begin
            midx_d  = midx_q + 1'b1;
            state_d = rau_pkg::BK_MUL_START;
          end
        end
      end

      rau_pkg::BK_COMBINE: begin
        state_d = rau_pkg::BK_RED_START;
        case (func_q)
          rau_pkg::FN_ADD: begin
            rn_d = p0_q + p1_q;
            rd_d = p2_q;
          end
          rau_pkg::FN_SUB: begin
            rn_d = p0_q - p1_q;
            rd_d = p2_q;
          end
          rau_pkg::FN_MUL: begin
            rn_d = p0_q;
            rd_d = p2_q;
          end
          rau_pkg::FN_DIV: begin
            rn_d = p0_q;
            rd_d = p1_q;
          end
          rau_pkg::FN_CMP: begin
            lt_d    = $signed(p0_q) < $signed(p1_q);
            eq_d    = p0_q == p1_q;
            gt_d    = $signed(p1_q) < $signed(p0_q);
            state_d = rau_pkg::BK_FIN;
          end
          default: begin
            // Maximum and minimum; a tie keeps the first operand.
            pick_b = (func_q == rau_pkg::FN_MAX) ? ($signed(p0_q) < $signed(p1_q))
                                                 : ($signed(p1_q) < $signed(p0_q));
            rn_d = pick_b ? bn_q : an_q;
            rd_d = pick_b ? bd_q : ad_q;
          end
        endcase
      end

      rau_pkg::BK_MOD: begin
        if (div_done) begin
          // Floored modulo: the remainder follows the sign of the divisor.
          modr = enc(an_q[W-1], div_r0);
          if (modr != '0 && modr[W-1] != bn_q[W-1]) modr = modr + bn_q;
          rn_d    = modr;
          state_d = rau_pkg::BK_FIN;
        end
      end

      rau_pkg::BK_FIN: begin
        if (out_free) begin
          out_d.num     = '0;
          out_d.den     = rau_pkg::DEN_W'(1);
          out_d.status  = st_q;
          out_d.less    = 1'b0;
          out_d.equal   = 1'b0;
          out_d.greater = 1'b0;
          if (st_q == rau_pkg::ST_OK) begin
            if (func_q == rau_pkg::FN_CMP) begin
              out_d.less    = lt_q;
              out_d.equal   = eq_q;
              out_d.greater = gt_q;
            end else if (func_q == rau_pkg::FN_MOD) begin
              out_d.num = rau_pkg::NUM_W'($signed(rn_q));
            end else if (rd_q == '0) begin
              out_d.status = rau_pkg::ST_DIV_ZERO;
            end else if (md[W-1]) begin
              out_d.status = rau_pkg::ST_RANGE;
            end else begin
              out_d.num = rau_pkg::NUM_W'($signed(enc(rn_q[W-1] ^ rd_q[W-1], mn)));
              out_d.den = rau_pkg::DEN_W'(md[W-2:0]);
            end
          end
          out_valid_d = 1'b1;
          state_d     = rau_pkg::BK_IDLE;
        end
      end

      default: state_d = rau_pkg::BK_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sim/rational_arithmetic_unit_tb.sv
// Self-checking testbench for the rational arithmetic unit: random and directed words.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit_tb;

  typedef struct {
    logic [3:0]  func;
    logic [63:0] an;
    logic [62:0] ad;
    logic [63:0] bn;
    logic [62:0] bd;
  } op_word_t;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  status;
    logic        less;
    logic        equal;
    logic        greater;
  } rat_result_t;

  localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DMAX = 64'h7fff_ffff_ffff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic [rau_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [rau_pkg::IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tready = 1'b0;
  wire s_axis_tready;
  wire m_axis_tvalid;
  wire [rau_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  wire [rau_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  rational_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  op_word_t    pending_words[$];
  rat_result_t expected_results[$];
  int          mismatches = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          hold_off_cycles = 0;

  function automatic logic is_neg(logic [63:0] x);
    return x[63];
  endfunction

  function automatic logic [63:0] magnitude(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
    logic [63:0] t;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    return (u != 0) ? u : 64'd1;
  endfunction

  function automatic logic [63:0] div_signed(logic [63:0] x, logic [63:0] g);
    logic [63:0] q;
    q = magnitude(x) / g;
    return is_neg(x) ? 64'd0 - q : q;
  endfunction

  function automatic void reduce_pair(inout logic [63:0] n, inout logic [63:0] d);
    logic [63:0] g;
    g = gcd64(magnitude(n), magnitude(d));
    n = div_signed(n, g);
    d = div_signed(d, g);
  endfunction

  function automatic logic signed_lt(logic [63:0] x, logic [63:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic void to_lowest(logic [63:0] n, logic [63:0] d, inout rat_result_t r);
    logic s;
    logic [63:0] mn, md, g;
    if (d == 0) begin
      r.status = rau_pkg::ST_DIV_ZERO;
      return;
    end
    s = is_neg(n) != is_neg(d);
    mn = magnitude(n);
    md = magnitude(d);
    g = gcd64(mn, md);
    mn = mn / g;
    md = md / g;
    if (md > DMAX) begin
      r.status = rau_pkg::ST_RANGE;
      return;
    end
    r.num = s ? 64'd0 - mn : mn;
    r.den = md[62:0];
  endfunction

  function automatic rat_result_t compute_rational(op_word_t w);
    rat_result_t r;
    logic [63:0] an, ad, bn, bd, n, d, l, rr, q, rem;
    logic unary;
    an = w.an; ad = {1'b0, w.ad}; bn = w.bn; bd = {1'b0, w.bd};
    unary = w.func inside {rau_pkg::FN_NEG, rau_pkg::FN_RECIP, rau_pkg::FN_ABS};
    r = '{num: 64'd0, den: 63'd1, status: rau_pkg::ST_OK, less: 0, equal: 0, greater: 0};
    if (w.func > rau_pkg::FN_MIN) r.status = rau_pkg::ST_RANGE;
    else if (ad == 0 || (!unary && bd == 0)) r.status = rau_pkg::ST_DIV_ZERO;
    else begin
      case (rau_pkg::func_e'(w.func))
        rau_pkg::FN_ADD: begin
          reduce_pair(an, ad);
          n = an * bd + bn * ad;
          d = ad * bd;
          reduce_pair(n, d);
          to_lowest(n, d, r);
        end
        rau_pkg::FN_SUB: begin
          n = an * bd - bn * ad;
          d = ad * bd;
          reduce_pair(n, d);
          to_lowest(n, d, r);
        end
        rau_pkg::FN_MUL: begin
          reduce_pair(an, ad);
          n = an * bn;
          d = ad * bd;
          reduce_pair(n, d);
          to_lowest(n, d, r);
        end
        rau_pkg::FN_DIV: begin
          if (bn == 0) r.status = rau_pkg::ST_DIV_ZERO;
          else begin
            n = an * bd;
            d = ad * bn;
            reduce_pair(n, d);
            to_lowest(n, d, r);
          end
        end
        rau_pkg::FN_NEG: to_lowest(64'd0 - an, ad, r);
        rau_pkg::FN_RECIP: begin
          if (an == 0) r.status = rau_pkg::ST_DIV_ZERO;
          else to_lowest(ad, an, r);
        end
        rau_pkg::FN_ABS: to_lowest(magnitude(an), ad, r);
        rau_pkg::FN_CMP: begin
          l = an * bd;
          rr = bn * ad;
          r.less = signed_lt(l, rr);
          r.equal = (l == rr);
          r.greater = signed_lt(rr, l);
        end
        rau_pkg::FN_MOD: begin
          if (ad != 1 || bd != 1) r.status = rau_pkg::ST_NOT_INT;
          else if (bn == 0) r.status = rau_pkg::ST_DIV_ZERO;
          else begin
            q = magnitude(an) % magnitude(bn);
            rem = is_neg(an) ? 64'd0 - q : q;
            // Floored modulo: the remainder follows the sign of the divisor.
            if (rem != 0 && is_neg(rem) != is_neg(bn)) rem = rem + bn;
            r.num = rem;
            r.den = 63'd1;
          end
        end
        default: begin
          l = an * bd;
          rr = bn * ad;
          if ((w.func == rau_pkg::FN_MAX && signed_lt(l, rr)) ||
              (w.func == rau_pkg::FN_MIN && signed_lt(rr, l)))
            to_lowest(bn, bd, r);
          else to_lowest(an, ad, r);
        end
      endcase
    end
    if (r.status != rau_pkg::ST_OK) begin
      r.num = 64'd0;
      r.den = 63'd1;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Numbers of mixed size so that small, exact cases and wrapping both appear.
  function automatic logic [63:0] pick_num();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return {{32{1'b0}}, $urandom} - 64'h8000_0000;
      3: return 64'($signed($urandom_range(0, 2000)) - 1000);
      4: return ($urandom_range(0, 1) != 0) ? HALF : DMAX;
      default: return 64'($urandom_range(0, 1000000));
    endcase
  endfunction

  function automatic logic [62:0] pick_den();
    case ($urandom_range(0, 5))
      0: return 63'(rand64());
      1, 2: return 63'($urandom_range(1, 12));
      3: return 63'd1;
      4: return 63'($urandom_range(0, 1) != 0 ? 0 : DMAX);
      default: return 63'($urandom_range(1, 100000));
    endcase
  endfunction

  function automatic void add_word(logic [3:0] f, logic [63:0] an, logic [62:0] ad,
                                   logic [63:0] bn, logic [62:0] bd);
    op_word_t w;
    w.func = f; w.an = an; w.ad = ad; w.bn = bn; w.bd = bd;
    pending_words.push_back(w);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: offers the next pending word, or idles at random.
  always @(posedge clk_i) begin
    op_word_t w;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) begin
          w.func = s_axis_tuser;
          w.an = s_axis_tdata[rau_pkg::A_NUM_LSB +: 64];
          w.ad = s_axis_tdata[rau_pkg::A_DEN_LSB +: 63];
          w.bn = s_axis_tdata[rau_pkg::B_NUM_LSB +: 64];
          w.bd = s_axis_tdata[rau_pkg::B_DEN_LSB +: 63];
          expected_results.push_back(compute_rational(w));
        end
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          w = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= w.func;
          s_axis_tdata <= {2'b00, w.bd, w.bn, w.ad, w.an};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and sets the sink's stall.
  always @(posedge clk_i) begin
    rat_result_t exp_r;
    rat_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.num = m_axis_tdata[63:0];
        got.den = m_axis_tdata[126:64];
        got.status = m_axis_tuser[1:0];
        got.less = m_axis_tuser[2];
        got.equal = m_axis_tuser[3];
        got.greater = m_axis_tuser[4];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word num=%h den=%h", got.num, got.den);
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: expected num=%h den=%h st=%0d lt/eq/gt=%b%b%b, ",
                        "got num=%h den=%h st=%0d lt/eq/gt=%b%b%b"},
                       exp_r.num, exp_r.den, exp_r.status, exp_r.less, exp_r.equal,
                       exp_r.greater, got.num, got.den, got.status, got.less, got.equal,
                       got.greater);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= snk_stall_pct;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    op_word_t w;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: every operation, field extremes and the error cases.
    for (int f = 0; f <= 15; f++) add_word(f[3:0], 64'd6, 63'd4, 64'hffff_ffff_ffff_fffd, 63'd9);
    add_word(rau_pkg::FN_ADD, HALF, DMAX[62:0], DMAX, 63'd1);
    add_word(rau_pkg::FN_SUB, 64'd1, 63'd0, 64'd1, 63'd1);
    add_word(rau_pkg::FN_DIV, 64'd5, 63'd3, 64'd0, 63'd7);
    add_word(rau_pkg::FN_RECIP, 64'd0, 63'd3, 64'd1, 63'd1);
    add_word(rau_pkg::FN_MUL, 64'd1, 63'h4000_0000_0000_0000, 64'd1, 63'd2);
    add_word(rau_pkg::FN_NEG, HALF, 63'd1, 64'd0, 63'd0);
    add_word(rau_pkg::FN_MOD, 64'd7, 63'd2, 64'd3, 63'd1);
    add_word(rau_pkg::FN_MOD, 64'hffff_ffff_ffff_fff9, 63'd1, 64'd3, 63'd1);
    add_word(rau_pkg::FN_MOD, 64'd7, 63'd1, 64'd0, 63'd1);

    n = 1900;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 73; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 73; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      if (ph == 0) hold_off_cycles = 3000;
      for (int i = 0; i < n / 4; i++) begin
        w.func = 4'($urandom_range(0, 11) == 11 ? $urandom_range(11, 15) : $urandom_range(0, 10));
        w.an = pick_num();
        w.ad = pick_den();
        w.bn = pick_num();
        w.bd = pick_den();
        if (w.func == rau_pkg::FN_MOD && $urandom_range(0, 3) != 0) begin
          w.ad = 63'd1;
          w.bd = 63'd1;
        end
        pending_words.push_back(w);
      end
      while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
